>>> rtl/core/sfcc_pkg.sv
// ----------------------------------------------------------------------------
// sfcc_pkg: shared types, constants and a function
// CRC-8 step function, conversion gains and offsets, fixed-point types.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcc_pkg;

    // CRC-8, polynomial x^8+x^5+x^4+1, MSB first, no reflection, no final XOR
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // 2^16 - 1; reading = round(gain * raw / FULL_SCALE) + offset (0 for RH)
    localparam logic [16:0] FULL_SCALE = 17'd65535;
    localparam logic [15:0] HALF_SCALE = 16'd32768;

    localparam logic [8:0] CEL_GAIN = 9'd175;   // degC span
    localparam logic [8:0] FAH_GAIN = 9'd315;   // 175 * 9 / 5
    localparam logic [8:0] HUM_GAIN = 9'd100;

    localparam logic signed [9:0] CEL_OFFSET = -10'sd45;
    localparam logic signed [9:0] FAH_OFFSET = -10'sd49;  // -45 * 9 / 5 + 32
    localparam logic [9:0]        HUM_MAX    = 10'd100;

    typedef logic [24:0] prod_t;   // gain * raw, below 2^25
    typedef logic [8:0]  quot_t;   // prod >> 16
    typedef logic [16:0] rem_t;    // low half plus quotient estimate
    typedef logic [9:0]  round_t;  // rounded quotient, 0..315

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sfcc_frame_if.sv
// ----------------------------------------------------------------------------
// sfcc_frame_if: sensor frame channel
// Valid/ready channel carrying one six-byte temperature and humidity frame.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcc_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] temp_msb;
    logic [7:0] temp_lsb;
    logic [7:0] temp_check;
    logic [7:0] hum_msb;
    logic [7:0] hum_lsb;
    logic [7:0] hum_check;

    modport source (output valid, output temp_msb, output temp_lsb, output temp_check,
                    output hum_msb, output hum_lsb, output hum_check, input ready);
    modport sink   (input valid, input temp_msb, input temp_lsb, input temp_check,
                    input hum_msb, input hum_lsb, input hum_check, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sfcc_result_if.sv
// ----------------------------------------------------------------------------
// sfcc_result_if: converted reading channel
// Valid/ready channel carrying CRC status and the rounded readings.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfcc_result_if;
    logic              valid;
    logic              ready;
    logic              temp_ok;
    logic              hum_ok;
    logic              reading_valid;
    logic signed [8:0] celsius;
    logic signed [9:0] fahrenheit;
    logic [6:0]        humidity_pct;

    modport source (output valid, output temp_ok, output hum_ok, output reading_valid,
                    output celsius, output fahrenheit, output humidity_pct,
                    input ready);
    modport sink   (input valid, input temp_ok, input hum_ok, input reading_valid,
                    input celsius, input fahrenheit, input humidity_pct,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/sensor_frame_check_convert.sv
// ----------------------------------------------------------------------------
// sensor_frame_check_convert: sensor frame CRC check and unit conversion
// Takes one frame per cycle unless the pipeline is full and the output is
// stalled, and returns one result item per frame. Each raw word is checked
// against its CRC-8 (poly 0x31, init 0xFF). When both match, reading_valid
// is set and the block gives round(-45 + 175*T/65535) degC, the matching
// degF from the unrounded Celsius value, and round(100*H/65535) percent RH;
// otherwise the three readings are zero. The three-stage pipeline (first CRC
// byte and constant multiply, second CRC byte and quotient estimate,
// correction and rounding into the output register) passes one item per
// cycle, and each stage holds its item while the next is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_check_convert (
    input  wire             clk,
    input  wire             rst_n,
    sfcc_frame_if.sink      frame,
    sfcc_result_if.source   reading
);

    // ---------------- stage handshake ----------------
    logic v1_reg, v2_reg, v3_reg;
    logic load1, load2, load3;

    assign load3       = !v3_reg || reading.ready;
    assign load2       = !v2_reg || load3;
    assign load1       = !v1_reg || load2;
    assign frame.ready = load1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (load1)
                v1_reg <= frame.valid;
            if (load2)
                v2_reg <= v1_reg;
            if (load3)
                v3_reg <= v2_reg;
        end
    end

    // ---------------- stage 1: first CRC byte, gain multiply ----------------
    logic [7:0]     t_lsb1_reg, h_lsb1_reg;
    logic [7:0]     t_crc1_reg, h_crc1_reg;
    logic [7:0]     t_chk1_reg, h_chk1_reg;
    sfcc_pkg::prod_t cel_prod1_reg, fah_prod1_reg, hum_prod1_reg;
    logic [15:0]    t_raw, h_raw;

    assign t_raw = {frame.temp_msb, frame.temp_lsb};
    assign h_raw = {frame.hum_msb, frame.hum_lsb};

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            t_lsb1_reg    <= frame.temp_lsb;
            h_lsb1_reg    <= frame.hum_lsb;
            t_crc1_reg    <= sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, frame.temp_msb);
            h_crc1_reg    <= sfcc_pkg::crc8_byte(sfcc_pkg::CRC_INIT, frame.hum_msb);
            t_chk1_reg    <= frame.temp_check;
            h_chk1_reg    <= frame.hum_check;
            cel_prod1_reg <= sfcc_pkg::prod_t'(t_raw) * sfcc_pkg::prod_t'(sfcc_pkg::CEL_GAIN);
            fah_prod1_reg <= sfcc_pkg::prod_t'(t_raw) * sfcc_pkg::prod_t'(sfcc_pkg::FAH_GAIN);
            hum_prod1_reg <= sfcc_pkg::prod_t'(h_raw) * sfcc_pkg::prod_t'(sfcc_pkg::HUM_GAIN);
        end
    end

    // ---------------- stage 2: second CRC byte, quotient estimate ----------------
    // p / 65535: q0 = p >> 16 is at most one short; remainder p - q0*65535
    // equals low half + q0, which stays below 2*65535.
    logic            t_ok2_reg, h_ok2_reg;
    sfcc_pkg::quot_t cel_q2_reg, fah_q2_reg, hum_q2_reg;
    sfcc_pkg::rem_t  cel_r2_reg, fah_r2_reg, hum_r2_reg;

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            t_ok2_reg  <= sfcc_pkg::crc8_byte(t_crc1_reg, t_lsb1_reg) == t_chk1_reg;
            h_ok2_reg  <= sfcc_pkg::crc8_byte(h_crc1_reg, h_lsb1_reg) == h_chk1_reg;
            cel_q2_reg <= cel_prod1_reg[24:16];
            fah_q2_reg <= fah_prod1_reg[24:16];
            hum_q2_reg <= hum_prod1_reg[24:16];
            cel_r2_reg <= {1'b0, cel_prod1_reg[15:0]} + sfcc_pkg::rem_t'(cel_prod1_reg[24:16]);
            fah_r2_reg <= {1'b0, fah_prod1_reg[15:0]} + sfcc_pkg::rem_t'(fah_prod1_reg[24:16]);
            hum_r2_reg <= {1'b0, hum_prod1_reg[15:0]} + sfcc_pkg::rem_t'(hum_prod1_reg[24:16]);
        end
    end

    // ---------------- stage 3: correction, rounding, offsets ----------------
    function automatic sfcc_pkg::round_t round_scale(input sfcc_pkg::quot_t q0,
                                                     input sfcc_pkg::rem_t r0);
        sfcc_pkg::round_t q;
        logic [15:0]      r;
        if (r0 >= sfcc_pkg::FULL_SCALE)
        begin
            q = sfcc_pkg::round_t'(q0) + 10'd1;
            r = 16'(r0 - sfcc_pkg::FULL_SCALE);
        end
        else
        begin
            q = sfcc_pkg::round_t'(q0);
            r = r0[15:0];
        end
        // odd divisor: no exact ties
        if (r >= sfcc_pkg::HALF_SCALE)
            q = q + 10'd1;
        return q;
    endfunction

    sfcc_pkg::round_t cel_round, fah_round, hum_round;
    logic             both_ok;
    logic signed [9:0] cel_full, fah_full;
    logic signed [8:0] celsius_next;
    logic signed [9:0] fahrenheit_next;
    logic [6:0]        humidity_next;

    always_comb
    begin
        cel_round = round_scale(cel_q2_reg, cel_r2_reg);
        fah_round = round_scale(fah_q2_reg, fah_r2_reg);
        hum_round = round_scale(hum_q2_reg, hum_r2_reg);
        both_ok   = t_ok2_reg && h_ok2_reg;
        cel_full  = $signed(cel_round) + sfcc_pkg::CEL_OFFSET;
        fah_full  = $signed(fah_round) + sfcc_pkg::FAH_OFFSET;
        if (both_ok)
        begin
            celsius_next    = cel_full[8:0];
            fahrenheit_next = fah_full;
            humidity_next   = (hum_round > sfcc_pkg::HUM_MAX) ? sfcc_pkg::HUM_MAX[6:0]
                                                               : hum_round[6:0];
        end
        else
        begin
            celsius_next    = '0;
            fahrenheit_next = '0;
            humidity_next   = '0;
        end
    end

    logic              temp_ok_reg, hum_ok_reg, reading_valid_reg;
    logic signed [8:0] celsius_reg;
    logic signed [9:0] fahrenheit_reg;
    logic [6:0]        humidity_reg;

    always_ff @(posedge clk)
    begin
        if (load3)
        begin
            temp_ok_reg       <= t_ok2_reg;
            hum_ok_reg        <= h_ok2_reg;
            reading_valid_reg <= both_ok;
            celsius_reg       <= celsius_next;
            fahrenheit_reg    <= fahrenheit_next;
            humidity_reg      <= humidity_next;
        end
    end

    assign reading.valid         = v3_reg;
    assign reading.temp_ok       = temp_ok_reg;
    assign reading.hum_ok        = hum_ok_reg;
    assign reading.reading_valid = reading_valid_reg;
    assign reading.celsius       = celsius_reg;
    assign reading.fahrenheit    = fahrenheit_reg;
    assign reading.humidity_pct  = humidity_reg;

    // ---------------- assertions ----------------
    a_valid_is_both_ok: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (reading_valid_reg == (temp_ok_reg && hum_ok_reg)))
        else $error("reading_valid disagrees with CRC status");

    a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !reading_valid_reg) |->
            (celsius_reg == 9'sd0 && fahrenheit_reg == 10'sd0 && humidity_reg == 7'd0))
        else $error("nonzero reading on CRC failure");

    a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && reading_valid_reg) |->
            (humidity_reg <= 7'd100 && celsius_reg >= -9'sd45 && celsius_reg <= 9'sd130
             && fahrenheit_reg >= -10'sd49 && fahrenheit_reg <= 10'sd266))
        else $error("reading out of range");

    a_stall_holds_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !reading.ready) |=> (v3_reg && $stable(celsius_reg)
                                        && $stable(fahrenheit_reg) && $stable(humidity_reg)))
        else $error("output stage changed while stalled");

    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && !reading.ready) |-> !frame.ready)
        else $error("frame accepted into a full pipeline");

endmodule

`default_nettype wire

>>> tb/tb_sensor_frame_check_convert.sv
// ----------------------------------------------------------------------------
// tb_sensor_frame_check_convert: self-checking bench for the frame converter
// Drives sensor frames through the valid/ready input channel. A table of
// directed frames comes first, then random frames in three flow-control
// phases. Every accepted result item is compared field by field with the row's
// typed reading or a local model of the CRC check and rounded unit conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sensor_frame_check_convert;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 4;
    localparam int LATENCY         = 3;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_CYCLES     = 150;
    localparam int RAND_PER_PHASE  = 476;
    localparam int NUM_ROWS        = 22;

    localparam logic [7:0] CRC_SEED = 8'hFF;
    localparam logic [7:0] CRC_GEN  = 8'h31;

    localparam longint SCALE      = 65535;
    localparam longint CEL_SPAN   = 175;
    localparam longint CEL_BASE   = 45;
    localparam longint FAH_MUL    = 9;
    localparam longint FAH_DIV    = 5;
    localparam longint FAH_BASE   = 32;
    localparam longint HUM_SPAN   = 100;
    localparam longint HUM_TOP    = 100;
    localparam longint ROUND_BIAS = 1024;

    typedef struct packed {
        logic [7:0] temp_msb;
        logic [7:0] temp_lsb;
        logic [7:0] temp_check;
        logic [7:0] hum_msb;
        logic [7:0] hum_lsb;
        logic [7:0] hum_check;
    } frame_t;

    typedef struct packed {
        logic              temp_ok;
        logic              hum_ok;
        logic              reading_valid;
        logic signed [8:0] celsius;
        logic signed [9:0] fahrenheit;
        logic [6:0]        humidity_pct;
    } reading_t;

    // seal: replace both check bytes with the correct CRC
    // typed: use the reading written in the row instead of the model
    typedef struct packed {
        logic [15:0] t_raw;
        logic [7:0]  t_crc;
        logic [15:0] h_raw;
        logic [7:0]  h_crc;
        logic        seal;
        logic        typed;
        reading_t    want;
    } frame_row_t;

    localparam reading_t NO_WANT = '0;

    frame_row_t directed_rows [NUM_ROWS] = '{
        '{16'h0000, 8'h81, 16'h0000, 8'h81, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, -9'sd45, -10'sd49, 7'd0}},
        '{16'hFFFF, 8'hAC, 16'hFFFF, 8'hAC, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, 9'sd130, 10'sd266, 7'd100}},
        '{16'h0000, 8'h81, 16'hFFFF, 8'hAC, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, -9'sd45, -10'sd49, 7'd100}},
        '{16'hFFFF, 8'hAC, 16'h0000, 8'h81, 1'b0, 1'b1,
          '{1'b1, 1'b1, 1'b1, 9'sd130, 10'sd266, 7'd0}},
        // bad temperature check, readings forced to zero
        '{16'h0000, 8'h82, 16'h0000, 8'h81, 1'b0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 9'sd0, 10'sd0, 7'd0}},
        '{16'h0000, 8'h81, 16'h0000, 8'h01, 1'b0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 9'sd0, 10'sd0, 7'd0}},
        '{16'hFFFF, 8'h53, 16'hFFFF, 8'h53, 1'b0, 1'b1,
          '{1'b0, 1'b0, 1'b0, 9'sd0, 10'sd0, 7'd0}},
        '{16'hFFFF, 8'hAC, 16'h0000, 8'h00, 1'b0, 1'b1,
          '{1'b1, 1'b0, 1'b0, 9'sd0, 10'sd0, 7'd0}},
        '{16'hBEEF, 8'h92, 16'hBEEF, 8'h92, 1'b0, 1'b0, NO_WANT},
        '{16'hBEEF, 8'h93, 16'hBEEF, 8'h92, 1'b0, 1'b1,
          '{1'b0, 1'b1, 1'b0, 9'sd0, 10'sd0, 7'd0}},
        '{16'h0001, 8'h00, 16'h0001, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'hFFFE, 8'h00, 16'hFFFE, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h8000, 8'h00, 16'h8000, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h7FFF, 8'h00, 16'h7FFF, 8'h00, 1'b1, 1'b0, NO_WANT},
        // around 0 degC and 0.5 %RH
        '{16'h41D3, 8'h00, 16'h0147, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h41D4, 8'h00, 16'h0148, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h5555, 8'h00, 16'hAAAA, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'hAAAA, 8'h00, 16'h5555, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h00FF, 8'h00, 16'hFF00, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'hFF00, 8'h00, 16'h00FF, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h1234, 8'h00, 16'hCDEF, 8'h00, 1'b1, 1'b0, NO_WANT},
        '{16'h3E2D, 8'h00, 16'hC1D2, 8'h00, 1'b1, 1'b0, NO_WANT}
    };

    logic clk = 1'b0;
    logic rst_n;

    sfcc_frame_if  frame_bus ();
    sfcc_result_if reading_bus ();

    sensor_frame_check_convert i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .frame   (frame_bus),
        .reading (reading_bus)
    );

    reading_t pending_readings [$];
    reading_t offer_want;
    int       mismatches = 0;
    int       send_idle_pct = 24;
    int       recv_idle_pct = 76;
    int       hold_asked = 0;

    always #(CLK_HALF) clk = ~clk;

    function automatic logic [7:0] word_crc(input logic [15:0] word);
        logic [7:0] c;
        logic       fb;
        c = CRC_SEED;
        for (int i = 15; i >= 0; i--)
        begin
            fb = c[7] ^ word[i];
            c  = {c[6:0], 1'b0} ^ (fb ? CRC_GEN : 8'h00);
        end
        return c;
    endfunction

    // num/den to nearest, ties to even; den > 0
    function automatic longint round_nearest(input longint num, input longint den);
        longint n;
        longint q;
        longint r;
        n = num + den * ROUND_BIAS;
        q = n / den;
        r = n % den;
        if (2 * r > den || (2 * r == den && q[0]))
            q++;
        return q - ROUND_BIAS;
    endfunction

    function automatic reading_t convert_frame(input frame_t f);
        reading_t    r;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        longint      cel_num;
        longint      hum;
        t_raw = {f.temp_msb, f.temp_lsb};
        h_raw = {f.hum_msb, f.hum_lsb};
        r = '0;
        r.temp_ok       = (word_crc(t_raw) == f.temp_check);
        r.hum_ok        = (word_crc(h_raw) == f.hum_check);
        r.reading_valid = r.temp_ok && r.hum_ok;
        if (r.reading_valid)
        begin
            // Celsius is cel_num / SCALE exactly
            cel_num = CEL_SPAN * longint'(t_raw) - CEL_BASE * SCALE;
            r.celsius = 9'(round_nearest(cel_num, SCALE));
            r.fahrenheit = 10'(round_nearest(FAH_MUL * cel_num + FAH_BASE * FAH_DIV * SCALE,
                                             FAH_DIV * SCALE));
            hum = round_nearest(HUM_SPAN * longint'(h_raw), SCALE);
            if (hum < 0)
                hum = 0;
            if (hum > HUM_TOP)
                hum = HUM_TOP;
            r.humidity_pct = 7'(hum);
        end
        return r;
    endfunction

    function automatic logic [15:0] pick_word();
        logic [15:0] w;
        w = 16'($urandom);
        if ($urandom_range(9) == 0)
        begin
            case ($urandom_range(3))
                0: w = 16'h0000;
                1: w = 16'hFFFF;
                2: w = 16'h0001;
                default: w = 16'hFFFE;
            endcase
        end
        return w;
    endfunction

    // mostly well-formed frames, the rest with one or both checks broken
    function automatic frame_t random_frame();
        frame_t      f;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        int          pick;
        t_raw = pick_word();
        h_raw = pick_word();
        pick  = $urandom_range(99);
        f = '{t_raw[15:8], t_raw[7:0], word_crc(t_raw), h_raw[15:8], h_raw[7:0],
              word_crc(h_raw)};
        if (pick >= 94)
        begin
            f.temp_check = 8'($urandom);
            f.hum_check  = 8'($urandom);
        end
        else if (pick >= 84)
            f.hum_check ^= 8'($urandom_range(255, 1));
        else if (pick >= 72)
            f.temp_check ^= 8'($urandom_range(255, 1));
        return f;
    endfunction

    task automatic check_field(input string name, input logic signed [31:0] want_v,
                               input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatches++;
            $display("%0t %s: expected %0d, got %0d", $time, name, want_v, got_v);
        end
    endtask

    task automatic offer_frame(input frame_t f, input reading_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            frame_bus.valid <= 1'b0;
            @(posedge clk);
        end
        frame_bus.valid      <= 1'b1;
        frame_bus.temp_msb   <= f.temp_msb;
        frame_bus.temp_lsb   <= f.temp_lsb;
        frame_bus.temp_check <= f.temp_check;
        frame_bus.hum_msb    <= f.hum_msb;
        frame_bus.hum_lsb    <= f.hum_lsb;
        frame_bus.hum_check  <= f.hum_check;
        offer_want           <= want;
        do
            @(posedge clk);
        while (!frame_bus.ready);
    endtask

    task automatic offer_random(input int count);
        frame_t f;
        for (int i = 0; i < count; i++)
        begin
            f = random_frame();
            offer_frame(f, convert_frame(f));
        end
    endtask

    // receiver: random back-pressure, plus a long hold-off on request
    initial
    begin : receiver
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left  = 0;
        reading_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_taken != hold_asked)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                reading_bus.ready <= 1'b0;
            end
            else
                reading_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // scoreboard and watchdog
    always @(posedge clk)
    begin : monitor
        reading_t want;
        int       quiet_cycles;
        if (rst_n)
        begin
            if (frame_bus.valid && frame_bus.ready)
                pending_readings.push_back(offer_want);
            if (reading_bus.valid && reading_bus.ready)
            begin
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t unexpected result item: expected none, got %0d %0d %0d",
                             $time, reading_bus.celsius, reading_bus.fahrenheit,
                             reading_bus.humidity_pct);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    check_field("temp_ok", want.temp_ok, reading_bus.temp_ok);
                    check_field("hum_ok", want.hum_ok, reading_bus.hum_ok);
                    check_field("reading_valid", want.reading_valid,
                                reading_bus.reading_valid);
                    check_field("celsius", want.celsius, reading_bus.celsius);
                    check_field("fahrenheit", want.fahrenheit, reading_bus.fahrenheit);
                    check_field("humidity_pct", want.humidity_pct,
                                reading_bus.humidity_pct);
                end
            end
            if ((frame_bus.valid && frame_bus.ready) ||
                (reading_bus.valid && reading_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("tb_sensor_frame_check_convert: FAIL");
                $finish;
            end
        end
        else
            quiet_cycles = 0;
    end

    initial
    begin : stimulus
        frame_row_t row;
        frame_t     f;
        reading_t   want;
        rst_n                = 1'b0;
        frame_bus.valid      = 1'b0;
        frame_bus.temp_msb   = '0;
        frame_bus.temp_lsb   = '0;
        frame_bus.temp_check = '0;
        frame_bus.hum_msb    = '0;
        frame_bus.hum_lsb    = '0;
        frame_bus.hum_check  = '0;
        offer_want           = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = directed_rows[i];
            f = '{row.t_raw[15:8], row.t_raw[7:0], row.t_crc, row.h_raw[15:8],
                  row.h_raw[7:0], row.h_crc};
            if (row.seal)
            begin
                f.temp_check = word_crc(row.t_raw);
                f.hum_check  = word_crc(row.h_raw);
            end
            want = row.typed ? row.want : convert_frame(f);
            offer_frame(f, want);
        end
        offer_random(RAND_PER_PHASE);

        // let the pipeline run dry before going on
        frame_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);

        send_idle_pct = 76;
        recv_idle_pct = 24;
        offer_random(RAND_PER_PHASE);

        // full rate, with a long hold-off on the output to back up the input
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked++;
        offer_random(RAND_PER_PHASE);

        frame_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        if (mismatches == 0)
            $display("tb_sensor_frame_check_convert: PASS");
        else
            $display("tb_sensor_frame_check_convert: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
